// ===== sv/mlfq_pkg.sv =====
// Shared types and constants of the multilevel feedback queue scheduler.
// Depends on nothing; every other file uses it.
package mlfq_pkg;

  typedef enum logic [1:0] {
    STAT_RAN      = 2'd0,
    STAT_EMPTY    = 2'd1,
    STAT_ADMITTED = 2'd2,
    STAT_REJECTED = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    REG_QUANTUM_TOP    = 2'd0,
    REG_QUANTUM_MIDDLE = 2'd1,
    REG_AGE_INTERVAL   = 2'd2,
    REG_UNUSED         = 2'd3
  } cfg_reg_t;

  localparam logic       REQ_ADMIT     = 1'b0;
  localparam logic       REQ_DISPATCH  = 1'b1;
  localparam logic [1:0] LEVEL_TOP     = 2'd0;
  localparam logic [1:0] LEVEL_MIDDLE  = 2'd1;
  localparam logic [1:0] LEVEL_BOTTOM  = 2'd2;
  localparam logic [15:0] QUANTUM_TOP_RST    = 16'd8;
  localparam logic [15:0] QUANTUM_MIDDLE_RST = 16'd16;
  localparam logic [15:0] AGE_INTERVAL_RST   = 16'd50;

  typedef struct packed {
    logic        req_type;
    logic [5:0]  slot;
    logic [31:0] arrival_time;
    logic [15:0] burst;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [5:0]  chosen_slot;
    logic [31:0] start_time;
    logic [15:0] run_length;
    logic        finished;
    logic        first_run;
    logic [1:0]  run_level;
    logic [31:0] now_time;
  } out_item_t;

  typedef struct packed {
    logic [1:0]  index;
    logic [15:0] data;
  } cfg_item_t;

  // One slot table entry, held in a single memory word.
  typedef struct packed {
    logic [1:0]  level;
    logic [15:0] remaining;
    logic [31:0] order_stamp;
    logic [31:0] wait_since;
    logic        started;
  } entry_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ADMIT,
    S_CHECK,
    S_AGE,
    S_SELECT,
    S_RUN,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic load_in;
    logic do_admit;
    logic mark_age;
    logic clr_sweep;
    logic age_phase;
    logic sel_phase;
    logic do_run;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic is_admit;
    logic age_due;
    logic sweep_done;
    logic out_free;
  } stat_t;

endpackage

// ===== sv/mlfq_in_if.sv =====
// Input channel of the scheduler: valid, ready and one request.
// Depends on mlfq_pkg.
interface mlfq_in_if;
  logic               valid;
  logic               ready;
  mlfq_pkg::in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== sv/mlfq_out_if.sv =====
// Result channel of the scheduler: valid, ready and one result.
// Depends on mlfq_pkg.
interface mlfq_out_if;
  logic                valid;
  logic                ready;
  mlfq_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== sv/mlfq_cfg_if.sv =====
// Configuration write channel: valid, ready, register index and data.
// Depends on mlfq_pkg.
interface mlfq_cfg_if;
  logic                valid;
  logic                ready;
  mlfq_pkg::cfg_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== sv/mlfq_ctrl.sv =====
// Sequencing state machine of the scheduler.
// Depends on mlfq_pkg; drives the datapath through command signals.
module mlfq_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  mlfq_pkg::stat_t stat,
  output mlfq_pkg::cmd_t  cmd
);
  import mlfq_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_nxt   = S_CHECK;
        end
      end
      S_CHECK: begin
        cmd.clr_sweep = 1'b1;
        if (stat.is_admit) begin
          state_nxt = S_ADMIT;
        end else if (stat.age_due) begin
          cmd.mark_age = 1'b1;
          state_nxt    = S_AGE;
        end else begin
          state_nxt = S_SELECT;
        end
      end
      S_ADMIT: begin
        cmd.do_admit = 1'b1;
        state_nxt    = S_EMIT;
      end
      S_AGE: begin
        cmd.age_phase = 1'b1;
        if (stat.sweep_done) begin
          cmd.clr_sweep = 1'b1;
          state_nxt     = S_SELECT;
        end
      end
      S_SELECT: begin
        cmd.sel_phase = 1'b1;
        if (stat.sweep_done) begin
          state_nxt = S_RUN;
        end
      end
      S_RUN: begin
        cmd.do_run = 1'b1;
        state_nxt  = S_EMIT;
      end
      S_EMIT: begin
        if (stat.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

// ===== sv/mlfq_dp.sv =====
// Datapath of the scheduler: slot table memory, valid bits, time and stamp
// registers, the scan pipeline, configuration registers and output register.
// Depends on mlfq_pkg and the channel interfaces.
module mlfq_dp #(
  parameter int NUM_SLOTS = 64
) (
  input  logic            clk,
  input  logic            rst_n,
  mlfq_in_if.sink         in_chan,
  mlfq_out_if.source      out_chan,
  mlfq_cfg_if.sink        cfg_chan,
  input  mlfq_pkg::cmd_t  cmd,
  output mlfq_pkg::stat_t stat
);
  import mlfq_pkg::*;

  localparam int IW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int CW = $clog2(NUM_SLOTS + 1);
  localparam logic [CW-1:0] CNT_END = CW'(NUM_SLOTS);

  entry_t mem [NUM_SLOTS];

  logic [NUM_SLOTS-1:0] valid_r;
  logic [15:0] q_top_r, q_mid_r, age_int_r;
  logic [31:0] now_r, last_age_r, next_stamp_r;
  in_item_t    req_r;
  out_item_t   res_r, out_r;
  out_item_t   res_nxt;
  logic        out_valid_r;

  logic [CW-1:0] cnt_r;
  logic          p_v_r;
  logic [IW-1:0] p_idx_r;
  entry_t        rd_q_r;

  logic          found_r;
  logic [IW-1:0] best_idx_r;
  logic [31:0]   best_age_r;
  entry_t        best_r;

  // Slot index of the request, in range check and table index.
  logic [31:0]   slot_ext;
  logic [IW-1:0] slot_idx;
  logic          slot_ok;
  logic [31:0]   best_ext;

  assign slot_ext = 32'(req_r.slot);
  assign slot_idx = slot_ext[IW-1:0];
  assign slot_ok  = (slot_ext < 32'(NUM_SLOTS)) && !valid_r[slot_idx];
  assign best_ext = 32'(best_idx_r);

  // Scan pipeline.
  logic          issue;
  logic [31:0]   age_limit;
  logic          age_hit;
  logic [31:0]   cand_age;
  logic          better;

  assign issue     = (cmd.age_phase || cmd.sel_phase) && (cnt_r != CNT_END);
  assign age_limit = {15'd0, age_int_r, 1'b0};
  assign age_hit   = p_v_r && cmd.age_phase && valid_r[p_idx_r] &&
                     ((now_r - rd_q_r.wait_since) >= age_limit);
  assign cand_age  = next_stamp_r - rd_q_r.order_stamp;
  assign better    = !found_r || (rd_q_r.level < best_r.level) ||
                     ((rd_q_r.level == best_r.level) && (cand_age > best_age_r));

  // Slice computation.
  logic [15:0] quantum, run_len, new_rem;
  always_comb begin
    case (best_r.level)
      LEVEL_TOP:    quantum = q_top_r;
      LEVEL_MIDDLE: quantum = q_mid_r;
      default:      quantum = best_r.remaining;
    endcase
    run_len = (best_r.remaining < quantum) ? best_r.remaining : quantum;
    new_rem = best_r.remaining - run_len;
  end

  // Result of an admit or a dispatch.
  always_comb begin
    res_nxt = '0;
    if (cmd.do_admit) begin
      res_nxt.chosen_slot = req_r.slot;
      if (slot_ok) begin
        res_nxt.status   = STAT_ADMITTED;
        res_nxt.now_time = (req_r.arrival_time > now_r) ? req_r.arrival_time : now_r;
      end else begin
        res_nxt.status   = STAT_REJECTED;
        res_nxt.now_time = now_r;
      end
    end else if (found_r) begin
      res_nxt.status      = STAT_RAN;
      res_nxt.chosen_slot = best_ext[5:0];
      res_nxt.start_time  = now_r;
      res_nxt.run_length  = run_len;
      res_nxt.finished    = (new_rem == 16'd0);
      res_nxt.first_run   = !best_r.started;
      res_nxt.run_level   = best_r.level;
      res_nxt.now_time    = now_r + 32'(run_len);
    end else begin
      res_nxt.status   = STAT_EMPTY;
      res_nxt.now_time = now_r;
    end
  end

  // Single memory write port.
  logic          wr_en;
  logic [IW-1:0] wr_addr;
  entry_t        wr_data;
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = p_idx_r;
    wr_data = rd_q_r;
    if (cmd.do_admit && slot_ok) begin
      wr_en   = 1'b1;
      wr_addr = slot_idx;
      wr_data = '{level: LEVEL_TOP, remaining: req_r.burst, order_stamp: next_stamp_r,
                  wait_since: req_r.arrival_time, started: 1'b0};
    end else if (age_hit) begin
      wr_en               = 1'b1;
      wr_data.level       = LEVEL_TOP;
      wr_data.order_stamp = next_stamp_r;
      wr_data.wait_since  = now_r;
    end else if (cmd.do_run && found_r) begin
      wr_en             = 1'b1;
      wr_addr           = best_idx_r;
      wr_data           = best_r;
      wr_data.remaining = new_rem;
      wr_data.started   = 1'b1;
      wr_data.order_stamp = next_stamp_r;
      wr_data.level     = (best_r.level == LEVEL_TOP) ? LEVEL_MIDDLE : LEVEL_BOTTOM;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (issue) begin
      rd_q_r <= mem[cnt_r[IW-1:0]];
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r      <= '0;
      now_r        <= '0;
      last_age_r   <= '0;
      next_stamp_r <= '0;
      q_top_r      <= QUANTUM_TOP_RST;
      q_mid_r      <= QUANTUM_MIDDLE_RST;
      age_int_r    <= AGE_INTERVAL_RST;
      cnt_r        <= '0;
      p_v_r        <= 1'b0;
      found_r      <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_chan.valid) begin
        case (cfg_chan.data.index)
          REG_QUANTUM_TOP:    q_top_r   <= cfg_chan.data.data;
          REG_QUANTUM_MIDDLE: q_mid_r   <= cfg_chan.data.data;
          REG_AGE_INTERVAL:   age_int_r <= cfg_chan.data.data;
          default: ;
        endcase
      end
      if (cmd.clr_sweep) begin
        cnt_r   <= '0;
        p_v_r   <= 1'b0;
        found_r <= 1'b0;
      end else begin
        p_v_r <= issue;
        if (issue) begin
          cnt_r <= cnt_r + 1'b1;
        end
      end
      if (cmd.mark_age) begin
        last_age_r <= now_r;
      end
      if (age_hit) begin
        next_stamp_r <= next_stamp_r + 32'd1;
      end
      if (p_v_r && cmd.sel_phase && valid_r[p_idx_r] && better) begin
        found_r <= 1'b1;
      end
      if (cmd.do_admit && slot_ok) begin
        valid_r[slot_idx] <= 1'b1;
        next_stamp_r      <= next_stamp_r + 32'd1;
        if (req_r.arrival_time > now_r) begin
          now_r <= req_r.arrival_time;
        end
      end
      if (cmd.do_run && found_r) begin
        now_r <= now_r + 32'(run_len);
        if (new_rem == 16'd0) begin
          valid_r[best_idx_r] <= 1'b0;
        end else begin
          next_stamp_r <= next_stamp_r + 32'd1;
        end
      end
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      req_r <= in_chan.data;
    end
    if (issue) begin
      p_idx_r <= cnt_r[IW-1:0];
    end
    if (p_v_r && cmd.sel_phase && valid_r[p_idx_r] && better) begin
      best_idx_r <= p_idx_r;
      best_age_r <= cand_age;
      best_r     <= rd_q_r;
    end
    if (cmd.do_admit || cmd.do_run) begin
      res_r <= res_nxt;
    end
    if (cmd.emit) begin
      out_r <= res_r;
    end
  end

  assign stat.is_admit   = (req_r.req_type == REQ_ADMIT);
  assign stat.age_due    = ((now_r - last_age_r) >= 32'(age_int_r));
  assign stat.sweep_done = (cnt_r == CNT_END) && !p_v_r;
  assign stat.out_free   = !out_valid_r || out_chan.ready;

  assign out_chan.valid = out_valid_r;
  assign out_chan.data  = out_r;
  assign cfg_chan.ready = 1'b1;

endmodule

// ===== sv/mlfq_scheduler.sv =====
// Top level of the three-level multilevel feedback queue scheduler.
// Depends on mlfq_pkg, the channel interfaces, mlfq_ctrl and mlfq_dp.
//
// Usage: requests arrive on in_chan (admit a process into a slot, or
// dispatch one time slice); each request yields exactly one result
// transaction on out_chan. Quantum lengths and the aging interval are
// written through cfg_chan, which is always ready; write it only while
// the scheduler is idle.
//
// An admit passes through the check, admit and emit states before its
// result is valid. A dispatch scans the slot table once to pick the
// oldest entry of the highest level, and when the aging interval has
// elapsed it scans once more beforehand to promote long-waiting
// processes. Each scan reads the slot table one entry per cycle.
// One request is processed at a time; in_chan.ready is high only while
// the scheduler waits for a new request.
//
// The result sits in an output register. The next request is accepted
// while that result waits; a stalled receiver only holds the scheduler
// at the point where a second result would be written.
//
// Reset (rst_n low at a clock edge) empties the slot table, zeroes time
// and ordering counters and restores default configuration values.
module mlfq_scheduler #(
  parameter int NUM_SLOTS = 64
) (
  input logic        clk,
  input logic        rst_n,
  mlfq_in_if.sink    in_chan,
  mlfq_out_if.source out_chan,
  mlfq_cfg_if.sink   cfg_chan
);
  import mlfq_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  mlfq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ready (in_chan.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  mlfq_dp #(
    .NUM_SLOTS (NUM_SLOTS)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .cfg_chan (cfg_chan),
    .cmd      (cmd),
    .stat     (stat)
  );

endmodule
